// ===== hdl/bhso_pkg.sv =====
`default_nettype none
package bhso_pkg;

    // Default sine table size (power of two)
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Field widths
    localparam int STEP_W     = 31;
    localparam int NH_W       = 14;
    localparam int SAMPLE_W   = 24;
    localparam int LEAK_W     = 16;
    localparam int COEF_W     = 20;
    localparam int ROM_W      = 16;
    localparam int PHASE_W    = 32;
    localparam int INTEG_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    // Register reset values
    localparam logic [LEAK_W-1:0]        LEAK_RST  = 16'd65208;
    localparam logic signed [COEF_W-1:0] COEF1_RST = -20'sd55738;
    localparam logic signed [COEF_W-1:0] COEF2_RST = 20'sd19158;
    localparam logic signed [COEF_W-1:0] COEF3_RST = 20'sd154082;

    // pi/2 in Q30 for the table build
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

    // Number of sine evaluations per sample, minus one
    localparam logic [2:0] SEL_LAST = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAK  = 2'd0,
        CFG_COEF1 = 2'd1,
        CFG_COEF2 = 2'd2,
        CFG_COEF3 = 2'd3
    } cfg_idx_t;

    // Sine evaluation slots
    typedef enum logic [2:0] {
        SEL_FUND  = 3'd0,
        SEL_SECND = 3'd1,
        SEL_DEN   = 3'd2,
        SEL_NUM1  = 3'd3,
        SEL_NUM2  = 3'd4
    } sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP1,
        ST_PREP2,
        ST_SRD,
        ST_SMUL,
        ST_SACC,
        ST_QMUL,
        ST_DIV,
        ST_DWAIT,
        ST_CLAMP,
        ST_KICK,
        ST_LEAK,
        ST_INTEG,
        ST_OUT1,
        ST_OUT2,
        ST_OUT3,
        ST_OUTSUM
    } state_t;

    // Two Taylor multiplies by x, each renormalized from Q60 to Q30
    function automatic longint unsigned tay_sq(input longint unsigned t,
                                               input longint unsigned x);
        longint unsigned u;
        u = (t * x) >> 30;
        return (u * x) >> 30;
    endfunction

    // Quarter-wave table entry g, argument g << shamt in Q0.32 of a cycle
    function automatic logic [ROM_W-1:0] rom_quarter(input int g, input int shamt);
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint s;
        r = longint'(g) << shamt;
        x = (r * HALFPI_Q30) >> 30;
        term = x;
        s = longint'(x);
        term = tay_sq(term, x) / 6;   s = s - longint'(term);
        term = tay_sq(term, x) / 20;  s = s + longint'(term);
        term = tay_sq(term, x) / 42;  s = s - longint'(term);
        term = tay_sq(term, x) / 72;  s = s + longint'(term);
        term = tay_sq(term, x) / 110; s = s - longint'(term);
        term = tay_sq(term, x) / 156; s = s + longint'(term);
        term = tay_sq(term, x) / 210; s = s - longint'(term);
        if (s < 0)
            s = 0;
        if (s > (longint'(1) << 30))
            s = longint'(1) << 30;
        s = (s * 32767 + (longint'(1) << 29)) >>> 30;
        return s[ROM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bhso_ram.sv =====
`default_nettype none
module bhso_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// ===== hdl/bhso_fill.sv =====
`default_nettype none
module bhso_fill
    import bhso_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    output logic                                    wr_en,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]      wr_addr,
    output logic [ROM_W-1:0]                        wr_data,
    output logic                                    done
);

    localparam int TAB_BITS = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int QTR      = TABLE_ENTRIES / 4;
    localparam int QIDX_W   = TAB_BITS - 1;

    logic [ROM_W-1:0]  qtab [0:QTR];
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [1:0]        quad;
    logic [QIDX_W-1:0] qidx;
    logic [ROM_W-1:0]  qval;

    // Build the quarter-wave table at elaboration
    for (genvar g = 0; g <= QTR; g++)
    begin : g_qtab
        localparam logic [ROM_W-1:0] QV = rom_quarter(g, 32 - TAB_BITS);
        assign qtab[g] = QV;
    end

    // Fold the running index onto the quarter wave
    always_comb
    begin
        quad = cnt_reg[TAB_BITS-1 -: 2];
        if (quad[0])
            qidx = QIDX_W'(QTR) - {1'b0, cnt_reg[TAB_BITS-3:0]};
        else
            qidx = {1'b0, cnt_reg[TAB_BITS-3:0]};
        qval = qtab[qidx];
    end

    always_comb
    begin
        wr_en   = !done_reg;
        wr_addr = cnt_reg;
        if (cnt_reg[TAB_BITS])
            wr_data = '0;
        else if (quad[1])
            wr_data = -qval;
        else
            wr_data = qval;
        done = done_reg;
    end

    // Advance one entry per cycle until the guard entry is written
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (!done_reg)
        begin
            cnt_next = cnt_reg + ADDR_W'(1);
            if (cnt_reg == ADDR_W'(TABLE_ENTRIES))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bhso_div.sv =====
`default_nettype none
module bhso_div
    import bhso_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [63:0]      quotient
);

    logic [63:0] work_reg;
    logic [63:0] work_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] dsr_reg;
    logic [31:0] dsr_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic [32:0] shifted;
    logic [33:0] trial;

    // One restoring step per cycle, quotient bits shift in behind the dividend
    always_comb
    begin
        shifted   = {rem_reg, work_reg[63]};
        trial     = {1'b0, shifted} - {2'b00, dsr_reg};
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[33])
                rem_next = shifted[31:0];
            else
                rem_next = trial[31:0];
            work_next = {work_reg[62:0], ~trial[33]};
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = work_reg;

endmodule
`default_nettype wire

// ===== hdl/blit_hardsync_sine_oscillator_top.sv =====
// Channel   Dir  Fields (low bit up)                          Transfer
// s_*       in   phase_step[30:0], harmonic_limit[44:31]      s_tvalid & s_tready
// m_*       out  sample[23:0]                                 m_tvalid & m_tready
// cfg_*     in   index 0..3, data[19:0]                       cfg_we
//
// After reset the sine table is swept into memory with s_tready low. A sample runs
// from the input transfer to m_tvalid through the 64-step divider that forms the
// impulse quotient; below 3 harmonics the divider is skipped, and at phase zero or a
// zero or negative denominator it is bypassed. No new input is taken until the sample
// is loaded. Table reads go through one dual-read memory, five interpolations, each a
// read, multiply and accumulate step in turn. One result waits in the output register
// while the next item is accepted; a stalled output holds the last state only.
`default_nettype none
module blit_hardsync_sine_oscillator_top
    import bhso_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // phase_step[30:0], harmonic_limit[44:31]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // sample[23:0]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TAB_BITS = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W   = $clog2(TABLE_ENTRIES + 1);

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [LEAK_W-1:0]        leak_reg;
    logic signed [COEF_W-1:0] c1_reg;
    logic signed [COEF_W-1:0] c2_reg;
    logic signed [COEF_W-1:0] c3_reg;

    // Oscillator state and per-sample operands
    logic [PHASE_W-1:0]        phase_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [NH_W-1:0]           nh_reg;
    logic [2:0]                sel_reg;
    logic [46:0]               tn1_reg;
    logic [46:0]               tn2_reg;

    // Sine unit
    logic [PHASE_W-1:0]  arg;
    logic [31:0]         frac;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [ROM_W-1:0]    rd_data_a;
    logic [ROM_W-1:0]    rd_data_b;
    logic signed [ROM_W-1:0] a_reg;
    logic signed [49:0]  sprod_reg;
    logic signed [50:0]  sine_sum;
    logic signed [31:0]  sine_val;
    logic signed [31:0]  s1_reg;
    logic signed [31:0]  s2_reg;
    logic signed [31:0]  den_reg;
    logic signed [31:0]  num1_reg;
    logic signed [31:0]  num2_reg;

    // Impulse train and integrator
    logic                special;
    logic                special_reg;
    logic [NH_W-1:0]     n2;
    logic signed [31:0]  q_opb;
    logic signed [63:0]  qprod_reg;
    logic [63:0]         dividend;
    logic                div_start;
    logic                div_busy;
    logic [63:0]         div_quo;
    logic signed [63:0]  q_val;
    logic signed [63:0]  q_clamped;
    logic signed [64:0]  q_round;
    logic signed [31:0]  b_reg;
    logic signed [63:0]  kick_reg;
    logic signed [48:0]  leakp_reg;
    logic signed [49:0]  leaked_w;
    logic signed [64:0]  kick_w;
    logic signed [41:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;

    // Output sum
    logic signed [51:0]  p1_reg;
    logic signed [51:0]  p2_reg;
    logic signed [51:0]  p3_reg;
    logic signed [61:0]  acc;
    logic signed [61:0]  acc_round;
    logic signed [SAMPLE_W-1:0] sample_sat;
    logic                out_load;
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;

    // Table fill
    logic              fill_we;
    logic [ADDR_W-1:0] fill_addr;
    logic [ROM_W-1:0]  fill_data;
    logic              fill_done;

    bhso_fill #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fill_we),
        .wr_addr (fill_addr),
        .wr_data (fill_data),
        .done    (fill_done)
    );

    bhso_ram #(
        .WIDTH (ROM_W),
        .DEPTH (TABLE_ENTRIES + 1)
    ) u_rom (
        .clk       (clk),
        .wr_en     (fill_we),
        .wr_addr   (fill_addr),
        .wr_data   (fill_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    bhso_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Select the sine argument for the current slot
    always_comb
    begin
        case (sel_reg)
            SEL_FUND:  arg = phase_reg;
            SEL_SECND: arg = phase_reg << 1;
            SEL_DEN:   arg = phase_reg >> 1;
            SEL_NUM1:  arg = tn1_reg[32:1] + 32'h4000_0000;
            SEL_NUM2:  arg = tn2_reg[32:1];
            default:   arg = phase_reg;
        endcase
        frac      = arg << TAB_BITS;
        rd_addr_a = {1'b0, arg[PHASE_W-1 -: TAB_BITS]};
        rd_addr_b = {1'b0, arg[PHASE_W-1 -: TAB_BITS]} + ADDR_W'(1);
    end

    // Interpolation: a*2^32 + (b-a)*frac, rounded from Q47 to Q30
    always_comb
    begin
        sine_sum = {{3{a_reg[ROM_W-1]}}, a_reg, 32'd0} + {sprod_reg[49], sprod_reg}
                   + 51'sd65536;
        sine_val = 32'(sine_sum >>> 17);
    end

    // Impulse quotient operands
    always_comb
    begin
        n2       = nh_reg - NH_W'(2);
        special  = (phase_reg == '0) || den_reg[31] || (den_reg == '0);
        q_opb    = special ? $signed({18'd0, n2}) : num2_reg;
        dividend = qprod_reg[63] ? 64'(-qprod_reg) : qprod_reg;
        if (special_reg)
            q_val = qprod_reg;
        else if (qprod_reg[63])
            q_val = -$signed(div_quo);
        else
            q_val = $signed(div_quo);
        if (q_val > (64'sd1 <<< 44))
            q_clamped = 64'sd1 <<< 44;
        else if (q_val < -(64'sd1 <<< 44))
            q_clamped = -(64'sd1 <<< 44);
        else
            q_clamped = q_val;
        q_round = ({q_clamped[63], q_clamped} + 65'sd8192) >>> 14;
    end

    // Leaky integrator update with saturation
    always_comb
    begin
        leaked_w  = $signed({leakp_reg[48], leakp_reg} + 50'sd32768) >>> 16;
        kick_w    = $signed({kick_reg[63], kick_reg} + 65'sd8388608) >>> 24;
        integ_sum = 42'(leaked_w) + 42'(kick_w);
        if (integ_sum > 42'sd2147483647)
            integ_sat = 32'sh7FFF_FFFF;
        else if (integ_sum < -42'sd2147483648)
            integ_sat = 32'sh8000_0000;
        else
            integ_sat = 32'(integ_sum);
    end

    // Output mix, rounded from Q46 to Q20
    always_comb
    begin
        acc       = 62'(p1_reg) + 62'(p2_reg) + (62'(p3_reg) <<< 6);
        acc_round = (acc + 62'sd33554432) >>> 26;
        if (acc_round > 62'sd8388607)
            sample_sat = 24'sh7F_FFFF;
        else if (acc_round < -62'sd8388608)
            sample_sat = 24'sh80_0000;
        else
            sample_sat = 24'(acc_round);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid && fill_done)
                    state_next = ST_PREP1;
            ST_PREP1:  state_next = ST_PREP2;
            ST_PREP2:  state_next = ST_SRD;
            ST_SRD:    state_next = ST_SMUL;
            ST_SMUL:   state_next = ST_SACC;
            ST_SACC:
                if (sel_reg == SEL_LAST)
                    state_next = ST_QMUL;
                else
                    state_next = ST_SRD;
            ST_QMUL:
                if (nh_reg < NH_W'(3))
                    state_next = ST_INTEG;
                else if (special)
                    state_next = ST_CLAMP;
                else
                    state_next = ST_DIV;
            ST_DIV:    state_next = ST_DWAIT;
            ST_DWAIT:
                if (!div_busy)
                    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_KICK;
            ST_KICK:   state_next = ST_LEAK;
            ST_LEAK:   state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_OUT1;
            ST_OUT1:   state_next = ST_OUT2;
            ST_OUT2:   state_next = ST_OUT3;
            ST_OUT3:   state_next = ST_OUTSUM;
            ST_OUTSUM:
                if (out_load)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE) && fill_done;
        div_start = (state_reg == ST_DIV);
        out_load  = (state_reg == ST_OUTSUM) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            integ_reg   <= '0;
            leak_reg    <= LEAK_RST;
            c1_reg      <= COEF1_RST;
            c2_reg      <= COEF2_RST;
            c3_reg      <= COEF3_RST;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold configuration until software writes it
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LEAK:  leak_reg <= cfg_data[LEAK_W-1:0];
                    CFG_COEF1: c1_reg   <= cfg_data;
                    CFG_COEF2: c2_reg   <= cfg_data;
                    CFG_COEF3: c3_reg   <= cfg_data;
                    default:   leak_reg <= leak_reg;
                endcase
            end

            // Advance the phase on each input transfer
            if (s_tvalid && s_tready)
                phase_reg <= phase_reg + {1'b0, s_tdata[STEP_W-1:0]};

            if (state_reg == ST_INTEG)
            begin
                if (nh_reg < NH_W'(3))
                    integ_reg <= '0;
                else
                    integ_reg <= integ_sat;
            end

            // Output register: drop on transfer, load the new sample
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            step_reg <= s_tdata[STEP_W-1:0];
            nh_reg   <= s_tdata[STEP_W +: NH_W];
            sel_reg  <= SEL_FUND;
        end
        case (state_reg)
            ST_PREP1:
                tn1_reg <= {15'd0, phase_reg} * {32'd0, {1'b0, nh_reg} + 15'd3};
            ST_PREP2:
                tn2_reg <= {15'd0, phase_reg} * {33'd0, n2};
            ST_SMUL:
            begin
                a_reg     <= rd_data_a;
                sprod_reg <= ($signed({rd_data_b[ROM_W-1], rd_data_b})
                              - $signed({rd_data_a[ROM_W-1], rd_data_a}))
                             * $signed({1'b0, frac});
            end
            ST_SACC:
            begin
                case (sel_reg)
                    SEL_FUND:  s1_reg   <= sine_val;
                    SEL_SECND: s2_reg   <= sine_val;
                    SEL_DEN:   den_reg  <= sine_val;
                    SEL_NUM1:  num1_reg <= sine_val;
                    default:   num2_reg <= sine_val;
                endcase
                sel_reg <= sel_reg + 3'd1;
            end
            ST_QMUL:
            begin
                qprod_reg   <= num1_reg * q_opb;
                special_reg <= special;
            end
            ST_CLAMP:
                b_reg <= 32'(q_round);
            ST_KICK:
                kick_reg <= b_reg * $signed({1'b0, step_reg});
            ST_LEAK:
                leakp_reg <= integ_reg * $signed({1'b0, leak_reg});
            ST_OUT1:
                p1_reg <= c1_reg * s1_reg;
            ST_OUT2:
                p2_reg <= (nh_reg < NH_W'(2)) ? 52'sd0 : c2_reg * s2_reg;
            ST_OUT3:
                p3_reg <= c3_reg * integ_reg;
            default:
                a_reg <= a_reg;
        endcase
        if (out_load)
            m_data_reg <= sample_sat;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== hdl/bhso_checker.sv =====
`default_nettype none
module bhso_checker
    import bhso_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // The block works on one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // A new result only follows a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

    // A result cannot appear right after an input transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind blit_hardsync_sine_oscillator_top bhso_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb
    import bhso_pkg::*;
();

    localparam int ROM_N = 1024;

    typedef struct {
        logic [STEP_W-1:0]   step;
        logic [NH_W-1:0]     nh;
        bit                  typed;
        logic [SAMPLE_W-1:0] val;
    } osc_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model of the oscillator
    shortint                    sine_tab [0:ROM_N];
    logic [PHASE_W-1:0]         osc_phase;
    longint                     osc_integ;
    logic [LEAK_W-1:0]          leak_r;
    logic signed [COEF_W-1:0]   coef_r [0:3];

    logic [SAMPLE_W-1:0] sample_q [$];
    int                  src_idle;
    int                  snk_idle;
    int                  mismatches;
    bit                  failed;

    blit_hardsync_sine_oscillator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Right shift rounding half up
    function automatic longint round_shr(input longint v, input int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Fill the sine table from a Taylor series on the folded quarter wave
    task automatic build_sine_tab();
        longint unsigned frac;
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint          s;
        int              quad;
        for (int i = 0; i < ROM_N; i++)
        begin
            frac = longint'(i) << 22;
            quad = int'((frac >> 30) & 3);
            r = frac & 64'h3FFF_FFFF;
            if (quad % 2 == 1)
                r = 64'h4000_0000 - r;
            x = (r * 64'd1686629713) >> 30;
            term = x;
            s = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            s = clip(s, 0, longint'(1) << 30);
            s = (s * 32767 + (longint'(1) << 29)) >>> 30;
            sine_tab[i] = (quad >= 2) ? shortint'(-s) : shortint'(s);
        end
        sine_tab[ROM_N] = 0;
    endtask

    // Interpolated sine of a cycle fraction, Q30
    function automatic longint sine_q30(input logic [31:0] x);
        logic [63:0] p;
        longint      a;
        longint      b;
        p = {22'b0, x, 10'b0};
        a = sine_tab[p[41:32]];
        b = sine_tab[int'(p[41:32]) + 1];
        return round_shr(a * 64'sh1_0000_0000 + (b - a) * longint'({32'b0, p[31:0]}), 17);
    endfunction

    // Impulse train value, Q16
    function automatic longint impulse_q16(input logic [31:0] t, input logic [NH_W-1:0] n);
        logic [63:0] prod;
        logic [31:0] arg;
        longint      den;
        longint      num1;
        longint      q;
        den = sine_q30({1'b0, t[31:1]});
        prod = {32'b0, t} * (64'(n) + 64'd3);
        arg = prod[32:1] + 32'h4000_0000;
        num1 = sine_q30(arg);
        if (t == 0 || den <= 0)
            q = num1 * (longint'(n) - 2);
        else
        begin
            prod = {32'b0, t} * (64'(n) - 64'd2);
            q = (num1 * sine_q30(prod[32:1])) / den;
        end
        q = clip(q, -(longint'(1) << 44), longint'(1) << 44);
        return round_shr(q, 14);
    endfunction

    // Advance the oscillator by one sample and return it
    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [STEP_W-1:0] step,
                                                        input logic [NH_W-1:0] n);
        longint acc;
        longint b;
        osc_phase = osc_phase + {1'b0, step};
        acc = longint'(coef_r[1]) * sine_q30(osc_phase);
        if (n >= 2)
            acc += longint'(coef_r[2]) * sine_q30({osc_phase[30:0], 1'b0});
        if (n >= 3)
        begin
            b = impulse_q16(osc_phase, n);
            osc_integ = clip(round_shr(osc_integ * longint'({48'b0, leak_r}), 16)
                             + round_shr(b * longint'({33'b0, step}), 24),
                             -(longint'(1) << 31), (longint'(1) << 31) - 1);
            acc += longint'(coef_r[3]) * osc_integ * 64;
        end
        else
            osc_integ = 0;
        acc = clip(round_shr(acc, 26), -8388608, 8388607);
        return acc[SAMPLE_W-1:0];
    endfunction

    // Offer one item, hold it until the transfer, then record the expectation
    task automatic send_item(input osc_row_t row);
        logic [SAMPLE_W-1:0] pred;
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, row.nh, row.step};
        do
            @(posedge clk);
        while (!s_tready);
        pred = next_sample(row.step, row.nh);
        sample_q.push_back(row.typed ? row.val : pred);
    endtask

    task automatic send_rand();
        osc_row_t row;
        int       pick;
        pick = $urandom_range(99);
        row.typed = 1'b0;
        row.val   = '0;
        row.step  = (pick < 60) ? STEP_W'($urandom) : STEP_W'($urandom_range(50000));
        pick = $urandom_range(99);
        if (pick < 10)
            row.nh = NH_W'($urandom_range(2));
        else if (pick < 60)
            row.nh = NH_W'($urandom_range(64, 3));
        else
            row.nh = NH_W'($urandom);
        send_item(row);
    endtask

    // Drop valid, wait for every expected sample, then let the block settle
    task automatic drain();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Present one register write for a single edge; the caller drops the enable
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_LEAK)
            leak_r = val[LEAK_W-1:0];
        else
            coef_r[idx] = val;
    endtask

    task automatic write_all(input logic [LEAK_W-1:0] leak, input logic [COEF_W-1:0] c1,
                             input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3);
        drain();
        write_reg(CFG_LEAK, {4'b0, leak});
        write_reg(CFG_COEF1, c1);
        write_reg(CFG_COEF2, c2);
        write_reg(CFG_COEF3, c3);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Compare every sample transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sample_q.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %h", m_tdata);
            end
            else if (m_tdata !== sample_q[0])
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("sample mismatch: expected %h actual %h", sample_q[0], m_tdata);
                void'(sample_q.pop_front());
            end
            else
                void'(sample_q.pop_front());
        end
    end

    // Stall the output side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        osc_row_t dir_rows [0:14];
        dir_rows = '{
            '{31'd0,          14'd0,     1'b1, 24'd0},
            '{31'd0,          14'd2,     1'b1, 24'd0},
            '{31'd0,          14'd3,     1'b1, 24'd0},
            '{31'd1,          14'd16383, 1'b0, 24'd0},
            '{31'd999,        14'd16383, 1'b0, 24'd0},
            '{31'd12345,      14'd3,     1'b0, 24'd0},
            '{31'h7FFF_FFFF,  14'd16383, 1'b0, 24'd0},
            '{31'h7FFF_FFFF,  14'd1,     1'b0, 24'd0},
            '{31'h4000_0000,  14'd2,     1'b0, 24'd0},
            '{31'h2AAA_AAAB,  14'd5,     1'b0, 24'd0},
            '{31'h5555_5555,  14'd8191,  1'b0, 24'd0},
            '{31'd4000000,    14'd100,   1'b0, 24'd0},
            '{31'd4000000,    14'd100,   1'b0, 24'd0},
            '{31'd88,         14'd3,     1'b0, 24'd0},
            '{31'h7FFF_FFFF,  14'd0,     1'b0, 24'd0}
        };

        // Hold all inputs at known values through reset
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_LEAK;
        cfg_data  = '0;
        src_idle  = 20;
        snk_idle  = 53;
        mismatches = 0;
        failed    = 1'b0;
        build_sine_tab();
        osc_phase = '0;
        osc_integ = 0;
        leak_r    = LEAK_RST;
        coef_r[0] = '0;
        coef_r[1] = COEF1_RST;
        coef_r[2] = COEF2_RST;
        coef_r[3] = COEF3_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows at reset settings
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // Extreme settings: strongest weights and no leak, then the opposite corner
        write_all(16'hFFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        foreach (dir_rows[i])
            if (!dir_rows[i].typed)
                send_item(dir_rows[i]);
        write_all(16'h0000, 20'h80000, 20'h80000, 20'h80000);
        repeat (20) send_rand();

        // Random traffic in three idle patterns, new settings each chunk
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            if (chunk == 2)
            begin
                src_idle = 53;
                snk_idle = 20;
            end
            else if (chunk == 4)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (chunk == 0)
                write_all(LEAK_RST, COEF1_RST, COEF2_RST, COEF3_RST);
            else
                write_all(LEAK_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom));
            repeat (205) send_rand();
        end

        drain();
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
